>>> design/ffra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit run allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int unsigned DEF_MAX_SLOTS = 1024;
    localparam int unsigned LEN_W         = 11;
    localparam int unsigned SLOT_W        = 10;
    localparam int unsigned FAIL_W        = 16;

    // Occupancy bit stored per slot
    localparam logic SLOT_FREE = 1'b0;
    localparam logic SLOT_OCC  = 1'b1;

    // Request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic cfg_load;
        logic load_req;
        logic clr_step;
        logic scan_start;
        logic scan_next;
        logic alloc_start;
        logic rel_start;
        logic fill_step;
        logic fin_ok;
        logic fin_none;
        logic fin_fail;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_release;
        logic rel_bad;
        logic len_zero;
        logic len_big;
        logic hit;
        logic scan_end;
        logic fill_last;
        logic can_push;
    } t_status;

endpackage
`default_nettype wire

>>> design/ffra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: clearing pass, request check, slot scan, range fill, result.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_cfg_valid,
    input  wire ffra_pkg::t_status i_st,
    output ffra_pkg::t_cmd         o_cmd,
    output logic                   o_in_stall,
    output logic                   o_cfg_ready,
    output logic                   o_busy
);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_CHECK   = 7'b0000100,
        S_SCAN_RD = 7'b0001000,
        S_SCAN_EV = 7'b0010000,
        S_FILL    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_load = 1'b1;
                    n_state = S_CLEAR;
                end else if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_st.is_release) begin
                    if (i_st.rel_bad) begin
                        o_cmd.fin_none = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.rel_start = 1'b1;
                        n_state = S_FILL;
                    end
                end else begin
                    priority if (i_st.len_zero) begin
                        o_cmd.fin_none = 1'b1;
                        n_state = S_DONE;
                    end else if (i_st.len_big) begin
                        o_cmd.fin_fail = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                priority if (i_st.hit) begin
                    o_cmd.alloc_start = 1'b1;
                    n_state = S_FILL;
                end else if (i_st.scan_end) begin
                    o_cmd.fin_fail = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_st.fill_last) begin
                    o_cmd.fin_ok = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_busy      = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> design/ffra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_dp
// Occupancy memory, scan counters, failure counter and output register.
// ----------------------------------------------------------------------------
module ffra_dp #(
    parameter int unsigned MAX_SLOTS = ffra_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffra_pkg::t_cmd                i_cmd,
    output ffra_pkg::t_status                  o_st,
    input  wire logic [ffra_pkg::LEN_W-1:0]    i_cfg_slots_in_use,
    input  wire logic                          i_req_type,
    input  wire logic [ffra_pkg::LEN_W-1:0]    i_run_length,
    input  wire logic [ffra_pkg::SLOT_W-1:0]   i_first_slot,
    input  wire logic [ffra_pkg::SLOT_W-1:0]   i_last_slot,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_granted,
    output logic [ffra_pkg::SLOT_W-1:0]        o_run_start,
    output logic [ffra_pkg::FAIL_W-1:0]        o_failure_count
);

    localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW = (AW + 1 > ffra_pkg::LEN_W) ? AW + 1 : ffra_pkg::LEN_W;
    localparam int unsigned FW = ffra_pkg::FAIL_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SLOTS);
    localparam logic [ffra_pkg::FAIL_W-1:0] FAIL_SAT = '1;

    logic          r_mem [MAX_SLOTS];
    logic          r_rdata;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_start;
    logic [CW-1:0] r_nslots;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_first;
    logic [CW-1:0] r_last;
    logic          r_type;
    logic          r_fill;
    logic          r_res_ok;
    logic [AW-1:0] r_res_start;
    logic [ffra_pkg::FAIL_W-1:0] r_fail;

    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] n_nslots;
    logic [CW-1:0] last_clip;
    logic [CW-1:0] start_ext;
    logic          we;
    logic          wdata;

    assign cfg_ext = CW'(i_cfg_slots_in_use);

    always_comb begin
        priority if (cfg_ext == '0) n_nslots = CW'(1);
        else if (cfg_ext > MAXC)    n_nslots = MAXC;
        else                        n_nslots = cfg_ext;
    end

    assign last_clip = (r_last > r_nslots - CW'(1)) ? r_nslots - CW'(1) : r_last;

    assign we    = i_cmd.clr_step || i_cmd.fill_step;
    assign wdata = i_cmd.clr_step ? ffra_pkg::SLOT_FREE : r_fill;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[r_addr] <= wdata;
        r_rdata <= r_mem[r_addr];
    end

    // Control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_nslots    <= MAXC;
            r_fail      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_load) begin
                r_nslots <= n_nslots;
                r_addr   <= '0;
            end
            if (i_cmd.clr_step || i_cmd.scan_next || i_cmd.fill_step) r_addr <= r_addr + AW'(1);
            if (i_cmd.scan_start) r_addr <= '0;
            if (i_cmd.rel_start) r_addr <= AW'(r_first);
            if (i_cmd.alloc_start) r_addr <= r_addr - AW'(r_len - CW'(1));
            if (i_cmd.fin_fail && r_fail != FAIL_SAT) r_fail <= r_fail + FW'(1);
            if (i_cmd.push) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type  <= i_req_type;
            r_len   <= CW'(i_run_length);
            r_first <= CW'(i_first_slot);
            r_last  <= CW'(i_last_slot);
        end
        if (i_cmd.scan_start) r_cnt <= '0;
        if (i_cmd.scan_next) r_cnt <= (r_rdata == ffra_pkg::SLOT_OCC) ? '0 : r_cnt + CW'(1);
        if (i_cmd.rel_start) begin
            r_end  <= AW'(last_clip);
            r_fill <= ffra_pkg::SLOT_FREE;
        end
        if (i_cmd.alloc_start) begin
            r_end   <= r_addr;
            r_start <= r_addr - AW'(r_len - CW'(1));
            r_fill  <= ffra_pkg::SLOT_OCC;
        end
        if (i_cmd.fin_ok) begin
            r_res_ok    <= 1'b1;
            r_res_start <= (r_type == ffra_pkg::REQ_RELEASE) ? '0 : r_start;
        end
        if (i_cmd.fin_none || i_cmd.fin_fail) begin
            r_res_ok    <= 1'b0;
            r_res_start <= '0;
        end
        if (i_cmd.push) begin
            o_granted       <= r_res_ok;
            o_run_start     <= start_ext[ffra_pkg::SLOT_W-1:0];
            o_failure_count <= r_fail;
        end
    end

    assign start_ext = CW'(r_res_start);

    assign o_st.clr_last   = (r_addr == AW'(MAX_SLOTS - 1));
    assign o_st.is_release = (r_type == ffra_pkg::REQ_RELEASE);
    assign o_st.rel_bad    = (r_first > r_last) || (r_first >= r_nslots);
    assign o_st.len_zero   = (r_len == '0);
    assign o_st.len_big    = (r_len > r_nslots);
    assign o_st.hit        = (r_rdata == ffra_pkg::SLOT_FREE) && (r_cnt + CW'(1) == r_len);
    assign o_st.scan_end   = (CW'(r_addr) == r_nslots - CW'(1));
    assign o_st.fill_last  = (r_addr == r_end);
    assign o_st.can_push   = !o_out_valid || !i_out_stall;

endmodule
`default_nettype wire

>>> design/first_fit_run_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_run_allocator_core
// Leftmost-fit allocator of contiguous slot runs, with range release.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate scans the occupancy memory
// from slot 0 with a read state and an evaluate state per slot visited (one
// read port, registered read data), stops at the first run of the requested
// length and then marks it occupied at one slot per cycle. A release marks
// its range free; refused requests and allocates longer than the row go
// straight to the result. The controller returns to idle after each result
// before the next request is taken, and a stalled output register holds the
// result step. After reset and after every write of the slot count a
// clearing pass over all MAX_SLOTS slots runs, during which no request is
// taken. A finished result sits in the output register while the next
// request is taken.
module first_fit_run_allocator_core #(
    parameter int unsigned MAX_SLOTS = ffra_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ffra_pkg::LEN_W-1:0]  i_cfg_slots_in_use,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_req_type,
    input  wire logic [ffra_pkg::LEN_W-1:0]  i_run_length,
    input  wire logic [ffra_pkg::SLOT_W-1:0] i_first_slot,
    input  wire logic [ffra_pkg::SLOT_W-1:0] i_last_slot,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_granted,
    output logic [ffra_pkg::SLOT_W-1:0]      o_run_start,
    output logic [ffra_pkg::FAIL_W-1:0]      o_failure_count
);

    ffra_pkg::t_cmd    cmd;
    ffra_pkg::t_status st;
    logic              busy;

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_busy      (busy)
    );

    ffra_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_st               (st),
        .i_cfg_slots_in_use (i_cfg_slots_in_use),
        .i_req_type         (i_req_type),
        .i_run_length       (i_run_length),
        .i_first_slot       (i_first_slot),
        .i_last_slot        (i_last_slot),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_granted          (o_granted),
        .o_run_start        (o_run_start),
        .o_failure_count    (o_failure_count)
    );

    a_refused_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_run_start == '0))
        else $error("refused result carries a nonzero start");

    // The output fields carry data only once a first result has been loaded.
    a_fail_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid)) |->
            (o_failure_count >= $past(o_failure_count)))
        else $error("failure count went down");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_in_stall && !o_cfg_ready))
        else $error("transfer possible while busy");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_cfg_ready))
        else $error("request taken during clearing pass");

endmodule
`default_nettype wire
